>>> rtl/bcd_clock_with_mux_display_assert.svh
// Assertion macros shared by the clock block. They use the signals clk and
// rst of the module that includes this file.
`ifndef BCD_CLOCK_WITH_MUX_DISPLAY_ASSERT_SVH
`define BCD_CLOCK_WITH_MUX_DISPLAY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCDC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCDC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bcdc_pkg.sv
package bcdc_pkg;

  // Reset values of the configuration registers.
  localparam logic [7:0] TICKS_PER_MINUTE_RESET = 8'd60;
  localparam logic [4:0] ALARM_HOURS_RESET      = 5'd6;
  localparam logic [5:0] ALARM_MINUTES_RESET    = 6'd30;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_TICKS_PER_MINUTE = 2'd0,
    CFG_ALARM_HOURS      = 2'd1,
    CFG_ALARM_MINUTES    = 2'd2,
    CFG_UNUSED           = 2'd3
  } cfg_index_t;

  // BCD time of day.
  typedef struct packed {
    logic [1:0] hour_tens;
    logic [3:0] hour_units;
    logic [2:0] minute_tens;
    logic [3:0] minute_units;
  } time_t;

  // One display result.
  typedef struct packed {
    logic [1:0] digit_index;
    logic [6:0] segments;
    logic       alarm_led;
    logic       pm_led;
  } result_t;

  // Seven-segment code, bit 0 is segment a; codes above nine are blank.
  function automatic logic [6:0] seg_of(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0:    s = 7'b0111111;
      4'd1:    s = 7'b0000110;
      4'd2:    s = 7'b1011011;
      4'd3:    s = 7'b1001111;
      4'd4:    s = 7'b1100110;
      4'd5:    s = 7'b1101101;
      4'd6:    s = 7'b1111101;
      4'd7:    s = 7'b0000111;
      4'd8:    s = 7'b1111111;
      4'd9:    s = 7'b1101111;
      default: s = 7'b0000000;
    endcase
    return s;
  endfunction

  // Binary hour from the BCD digits.
  function automatic logic [5:0] hours_bin(input time_t t);
    return 6'({4'd0, t.hour_tens} * 6'd10) + {2'd0, t.hour_units};
  endfunction

  // Binary minute from the BCD digits.
  function automatic logic [6:0] minutes_bin(input time_t t);
    return 7'({4'd0, t.minute_tens} * 7'd10) + {3'd0, t.minute_units};
  endfunction

endpackage

>>> rtl/bcd_clock_with_mux_display.sv
// BCD clock with a multiplexed four-digit seven-segment display.
// Input channel (in_valid/in_ready, toggle_format): one transaction is one
// multiplex tick; toggle_format of 1 flips 12/24-hour display mode first.
// Output channel (out_valid/out_ready): one result per tick with the digit
// position, its segment pattern, and the alarm and PM LEDs.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// ticks per minute, 1 alarm hour, 2 alarm minute; always ready. The user must
// write it only while the block is idle; the block does not enforce this.
// An accepted tick sits in the input register, and the result register loads
// from it when the input stage moves on, so a stall can hold it in between.
// Throughput: one tick per cycle while the receiver does not stall; the state
// update between the two registers is combinational.
// Reset clears the time to 00:00 in 24-hour mode, the digit pointer and tick
// counter to zero, and loads the register defaults (60, 06, 30).
// When the receiver stalls, the result register holds and one more tick is
// kept in the input register; after that in_ready drops until out_ready.
module bcd_clock_with_mux_display (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       toggle_format,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] digit_index,
  output logic [6:0] segments,
  output logic       alarm_led,
  output logic       pm_led,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import bcdc_pkg::*;

  `include "bcd_clock_with_mux_display_assert.svh"

  logic       s1_valid;
  logic       s1_toggle;
  logic       s1_go;
  logic [7:0] ticks_per_minute;
  logic [4:0] alarm_hours;
  logic [5:0] alarm_minutes;
  time_t      cur;
  time_t      nxt;
  logic       show_24_next;
  logic [1:0] pointer;
  result_t    res;

  // The input stage moves on whenever the result register is free or drains.
  assign s1_go     = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_go;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_minute <= TICKS_PER_MINUTE_RESET;
      alarm_hours      <= ALARM_HOURS_RESET;
      alarm_minutes    <= ALARM_MINUTES_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_TICKS_PER_MINUTE: ticks_per_minute <= cfg_data;
        CFG_ALARM_HOURS:      alarm_hours      <= cfg_data[4:0];
        CFG_ALARM_MINUTES:    alarm_minutes    <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_toggle <= toggle_format;
    end
  end

  bcdc_counter u_counter (
    .clk              (clk),
    .rst              (rst),
    .step             (s1_go),
    .toggle           (s1_toggle),
    .ticks_per_minute (ticks_per_minute),
    .cur              (cur),
    .nxt              (nxt),
    .show_24_next     (show_24_next),
    .pointer          (pointer)
  );

  bcdc_display u_display (
    .cur           (cur),
    .nxt           (nxt),
    .show_24       (show_24_next),
    .pointer       (pointer),
    .alarm_hours   (alarm_hours),
    .alarm_minutes (alarm_minutes),
    .res           (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      digit_index <= res.digit_index;
      segments    <= res.segments;
      alarm_led   <= res.alarm_led;
      pm_led      <= res.pm_led;
    end
  end

  // An empty result register never blocks the input.
  `BCDC_ASSERT_SAME(a_ready_when_empty, !out_valid, in_ready,
                    "input stalled with an empty result register")
  // A stalled input stage keeps its tick.
  `BCDC_ASSERT_NEXT(a_s1_hold, s1_valid && !s1_go, s1_valid && $stable(s1_toggle),
                    "input stage lost a pending tick")
  // A loaded result shows the digit position the pointer held.
  `BCDC_ASSERT_NEXT(a_result_loaded, s1_go, out_valid && digit_index == $past(pointer),
                    "result register not loaded from the current digit")

endmodule

>>> rtl/bcdc_counter.sv
module bcdc_counter (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           toggle,
  input  logic [7:0]     ticks_per_minute,
  output bcdc_pkg::time_t cur,
  output bcdc_pkg::time_t nxt,
  output logic           show_24_next,
  output logic [1:0]     pointer
);
  import bcdc_pkg::*;

  `include "bcd_clock_with_mux_display_assert.svh"

  logic [7:0] tick_count;
  logic [7:0] tick_inc;
  logic       show_24_hour;
  logic       minute_due;
  time_t      t;

  // The tick counter rolls a minute when the incremented count matches.
  assign tick_inc     = tick_count + 8'd1;
  assign minute_due   = (tick_inc == ticks_per_minute);
  assign show_24_next = show_24_hour ^ toggle;

  // BCD minute and hour advance with the 23:59 to 00:00 wrap.
  always_comb begin
    t = cur;
    if (minute_due) begin
      t.minute_units = cur.minute_units + 4'd1;
      if (t.minute_units >= 4'd10) begin
        t.minute_units = 4'd0;
        t.minute_tens  = t.minute_tens + 3'd1;
      end
      if (t.minute_tens >= 3'd6) begin
        t.minute_tens = 3'd0;
        t.hour_units  = t.hour_units + 4'd1;
        if (t.hour_units >= 4'd10) begin
          t.hour_units = 4'd0;
          t.hour_tens  = t.hour_tens + 2'd1;
        end
        if (t.hour_tens == 2'd2 && t.hour_units == 4'd4) begin
          t.hour_tens  = 2'd0;
          t.hour_units = 4'd0;
        end
      end
    end
    nxt = t;
  end

  // State registers move once per transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur          <= '0;
      tick_count   <= 8'd0;
      pointer      <= 2'd0;
      show_24_hour <= 1'b1;
    end else if (step) begin
      cur          <= nxt;
      tick_count   <= minute_due ? 8'd0 : tick_inc;
      pointer      <= pointer + 2'd1;
      show_24_hour <= show_24_next;
    end
  end

  // The time stays a legal time of day.
  `BCDC_ASSERT_SAME(a_minute_legal, 1'b1,
                    cur.minute_units < 4'd10 && cur.minute_tens < 3'd6,
                    "minute digits out of range")
  `BCDC_ASSERT_SAME(a_hour_legal, 1'b1, hours_bin(cur) < 6'd24,
                    "hour out of range")
  // The time holds when no transaction steps it.
  `BCDC_ASSERT_NEXT(a_hold_idle, !step, cur == $past(cur) && pointer == $past(pointer),
                    "state changed without a transaction")

endmodule

>>> rtl/bcdc_display.sv
module bcdc_display (
  input  bcdc_pkg::time_t   cur,
  input  bcdc_pkg::time_t   nxt,
  input  logic              show_24,
  input  logic [1:0]        pointer,
  input  logic [4:0]        alarm_hours,
  input  logic [5:0]        alarm_minutes,
  output bcdc_pkg::result_t res
);
  import bcdc_pkg::*;

  logic [5:0] h;
  logic [5:0] h12;
  logic [1:0] tens12;
  logic [3:0] units12;
  logic [1:0] disp_ht;
  logic [3:0] disp_hu;
  logic [3:0] digit;
  logic [5:0] hours_after;

  // Twelve-hour conversion of the hour before this tick's advance.
  always_comb begin
    h = hours_bin(cur);
    if (h == 6'd0) begin
      h12 = 6'd12;
    end else if (h > 6'd12) begin
      h12 = h - 6'd12;
    end else begin
      h12 = h;
    end
    if (h12 >= 6'd30) begin
      tens12 = 2'd3;
    end else if (h12 >= 6'd20) begin
      tens12 = 2'd2;
    end else if (h12 >= 6'd10) begin
      tens12 = 2'd1;
    end else begin
      tens12 = 2'd0;
    end
    units12 = 4'(h12 - 6'({4'd0, tens12} * 6'd10));
    disp_ht = show_24 ? cur.hour_tens  : tens12;
    disp_hu = show_24 ? cur.hour_units : units12;
  end

  // Digit select for the multiplex position.
  always_comb begin
    case (pointer)
      2'd0:    digit = cur.minute_units;
      2'd1:    digit = {1'b0, cur.minute_tens};
      2'd2:    digit = disp_hu;
      default: digit = {2'd0, disp_ht};
    endcase
  end

  // The LEDs reflect the time after the advance.
  assign hours_after     = hours_bin(nxt);
  assign res.digit_index = pointer;
  assign res.segments    = seg_of(digit);
  assign res.alarm_led   = (hours_after == {1'b0, alarm_hours}) &&
                           (minutes_bin(nxt) == {1'b0, alarm_minutes});
  assign res.pm_led      = (hours_after >= 6'd12);

endmodule
